@@ sv/ipv4_header_builder_assert.svh @@
// Assertion macros used by the header builder top level.
`ifndef IPV4_HEADER_BUILDER_ASSERT_SVH
`define IPV4_HEADER_BUILDER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define IHB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define IHB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/ihb_pkg.sv @@
// Types and constants of the IPv4 header builder.
package ihb_pkg;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] total_length;
    logic [7:0]  protocol;
    logic [15:0] identification;
  } ihb_req_t;

  typedef struct packed {
    logic [15:0] header_word;
    logic [3:0]  word_index;
    logic        last;
  } ihb_res_t;

  // Header job as queued between front and back.
  typedef struct packed {
    ihb_req_t    req;
    logic [7:0]  ttl;
    logic        df;
    logic [19:0] sum;
  } ihb_job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } ihb_qstat_t;

  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_TTL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DF  = 1'd1;

  localparam logic [7:0] TTL_RESET = 8'hff;
  localparam logic       DF_RESET  = 1'b1;

  localparam logic [15:0] VER_IHL_WORD = 16'h4500;
  localparam logic [15:0] DF_WORD      = 16'h4000;

  localparam logic [3:0] W_VER   = 4'd0;
  localparam logic [3:0] W_LEN   = 4'd1;
  localparam logic [3:0] W_ID    = 4'd2;
  localparam logic [3:0] W_FRAG  = 4'd3;
  localparam logic [3:0] W_TTL   = 4'd4;
  localparam logic [3:0] W_CSUM  = 4'd5;
  localparam logic [3:0] W_SRC_H = 4'd6;
  localparam logic [3:0] W_SRC_L = 4'd7;
  localparam logic [3:0] W_DST_H = 4'd8;
  localparam logic [3:0] W_DST_L = 4'd9;

endpackage

@@ sv/ihb_front.sv @@
// Front end: configuration registers and per-request checksum sum.
module ihb_front import ihb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  ihb_req_t             req,
  output ihb_job_t             job
);

  logic [7:0] ttl;
  logic       df;
  logic [15:0] frag_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      ttl <= TTL_RESET;
      df  <= DF_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TTL: ttl <= cfg_data;
        REG_DF:  df  <= cfg_data[0];
      endcase
    end
  end

  assign frag_word = df ? DF_WORD : 16'h0000;

  // Raw sum of the nine non-checksum words; folded in the back end.
  always_comb begin
    job.req = req;
    job.ttl = ttl;
    job.df  = df;
    job.sum = 20'(VER_IHL_WORD) + 20'(req.total_length) + 20'(req.identification)
            + 20'(frag_word) + 20'({ttl, req.protocol})
            + 20'(req.src_addr[31:16]) + 20'(req.src_addr[15:0])
            + 20'(req.dst_addr[31:16]) + 20'(req.dst_addr[15:0]);
  end

endmodule

@@ sv/ihb_queue.sv @@
// Small job queue between front and back ends.
module ihb_queue import ihb_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr,
  input  ihb_job_t   wr_job,
  input  logic       rd,
  output ihb_job_t   rd_job,
  output ihb_qstat_t stat
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ihb_job_t        slots [DEPTH];
  logic [AW-1:0]   wptr;
  logic [AW-1:0]   rptr;
  logic [CW-1:0]   count;

  assign stat.empty = (count == '0);
  assign stat.full  = (count == CW'(DEPTH));
  assign rd_job     = slots[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ sv/ihb_back.sv @@
// Back end: walks a queued job word by word into the output register.
module ihb_back import ihb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     job_valid,
  input  ihb_job_t job,
  output logic     job_done,
  input  logic     pop,
  output logic     empty,
  output ihb_res_t res
);

  logic [3:0]  idx;
  logic        res_valid;
  logic        load;
  logic [16:0] fold1;
  logic [16:0] fold2;
  logic [15:0] csum;
  logic [15:0] word;

  assign empty    = !res_valid;
  assign load     = job_valid && (!res_valid || pop);
  assign job_done = load && (idx == W_DST_L);

  // End-around carry: two folds cover a 20-bit sum.
  assign fold1 = 17'(job.sum[15:0]) + 17'(job.sum[19:16]);
  assign fold2 = 17'(fold1[15:0]) + 17'(fold1[16]);
  assign csum  = ~fold2[15:0];

  always_comb begin
    unique case (idx)
      W_VER:   word = VER_IHL_WORD;
      W_LEN:   word = job.req.total_length;
      W_ID:    word = job.req.identification;
      W_FRAG:  word = job.df ? DF_WORD : 16'h0000;
      W_TTL:   word = {job.ttl, job.req.protocol};
      W_CSUM:  word = csum;
      W_SRC_H: word = job.req.src_addr[31:16];
      W_SRC_L: word = job.req.src_addr[15:0];
      W_DST_H: word = job.req.dst_addr[31:16];
      W_DST_L: word = job.req.dst_addr[15:0];
      default: word = 16'h0000;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= W_VER;
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
      idx       <= (idx == W_DST_L) ? W_VER : idx + 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res.header_word <= word;
      res.word_index  <= idx;
      res.last        <= (idx == W_DST_L);
    end
  end

endmodule

@@ sv/ipv4_header_builder.sv @@
// Top level of the IPv4 header builder.
//
//  channel   signals                         beat
//  request   push, full, req                 one header request
//  result    empty, pop, res                 one 16-bit header word
//  config    cfg_write, cfg_index, cfg_data  one register write
//
// Each request yields ten result beats, one per cycle while pop is held, so
// the output word port sets the sustained request rate.
// When idle, an accepted request is first written into the job queue, and
// its first word is then registered into the output register.
// The job queue holds DEPTH requests; full rises only when it is filled.
// Synchronous reset empties the queue and output register and restores TTL 255
// and don't-fragment set.
module ipv4_header_builder import ihb_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  ihb_req_t              req,
  output logic                  empty,
  input  logic                  pop,
  output ihb_res_t              res,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  `include "ipv4_header_builder_assert.svh"

  ihb_job_t   new_job;
  ihb_job_t   head_job;
  ihb_qstat_t qstat;
  logic       accept;
  logic       job_done;

  assign full   = qstat.full;
  assign accept = push && !qstat.full;

  ihb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .job       (new_job)
  );

  ihb_queue #(.DEPTH(DEPTH)) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (accept),
    .wr_job (new_job),
    .rd     (job_done),
    .rd_job (head_job),
    .stat   (qstat)
  );

  ihb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (!qstat.empty),
    .job       (head_job),
    .job_done  (job_done),
    .pop       (pop),
    .empty     (empty),
    .res       (res)
  );

  `IHB_ASSERT_NEXT(a_queue_fill, accept, !qstat.empty, "accepted request not queued")
  `IHB_ASSERT_NEXT(a_word_seq, pop && !empty && !res.last,
    empty || (res.word_index == $past(res.word_index) + 4'd1), "word index skipped")
  `IHB_ASSERT_NEXT(a_header_restart, pop && !empty && res.last,
    empty || (res.word_index == W_VER), "header does not restart at word zero")
  `IHB_ASSERT_IMPL(a_done_has_job, job_done, !qstat.empty, "job retired from empty queue")

endmodule

@@ test/ipv4_header_builder_tb.sv @@
// Self-checking testbench for the IPv4 header builder with its own header and checksum model.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ihb_pkg::*;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;
  localparam int HEADER_WORDS   = 10;
  localparam int DRAIN_CYCLES   = 6;
  localparam int RANDOM_PHASES  = 5;
  localparam int PHASE_REQUESTS = 76;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  push = 1'b0;
  logic                  full;
  ihb_req_t              req = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  ihb_res_t              res;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Register copies as the block should hold them.
  logic [7:0] ttl_setting = 8'hFF;
  logic       df_setting = 1'b1;

  ihb_req_t request_backlog[$];
  ihb_res_t header_words_due[$];
  int       requests_sent = 0;
  int       requests_taken = 0;
  int       mismatch_count = 0;
  int       gap_left = 0;
  int       stall_left = 0;
  bit       quiet = 1'b1;

  ipv4_header_builder i_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req       (req),
    .empty     (empty),
    .pop       (pop),
    .res       (res),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Expand one request into its ten header words under the current settings.
  function automatic void build_header(ihb_req_t r);
    logic [15:0] words [HEADER_WORDS];
    logic [31:0] acc;
    ihb_res_t    beat;
    words[W_VER]   = {4'd4, 4'd5, 8'h00};
    words[W_LEN]   = r.total_length;
    words[W_ID]    = r.identification;
    words[W_FRAG]  = {1'b0, df_setting, 14'd0};
    words[W_TTL]   = {ttl_setting, r.protocol};
    words[W_CSUM]  = 16'h0000;
    words[W_SRC_H] = r.src_addr[31:16];
    words[W_SRC_L] = r.src_addr[15:0];
    words[W_DST_H] = r.dst_addr[31:16];
    words[W_DST_L] = r.dst_addr[15:0];
    acc = '0;
    for (int i = 0; i < HEADER_WORDS; i++) acc += words[i];
    // fold carries back in twice, then invert
    acc = acc[15:0] + acc[31:16];
    acc = acc[15:0] + acc[31:16];
    words[W_CSUM] = ~acc[15:0];
    for (int i = 0; i < HEADER_WORDS; i++) begin
      beat.header_word = words[i];
      beat.word_index  = 4'(i);
      beat.last        = (i == HEADER_WORDS - 1);
      header_words_due.push_back(beat);
    end
  endfunction

  function automatic void note_mismatch(string field, int want, int got);
    $display("%0t: %s expected %0h got %0h", $time, field, want, got);
    mismatch_count++;
  endfunction

  function automatic void check_word(ihb_res_t got);
    ihb_res_t want;
    if (header_words_due.size() == 0) begin
      $display("%0t: unexpected header word %h index %0d", $time, got.header_word,
               got.word_index);
      mismatch_count++;
      return;
    end
    want = header_words_due.pop_front();
    if (got.header_word !== want.header_word)
      note_mismatch($sformatf("header_word[%0d]", want.word_index), want.header_word,
                    got.header_word);
    if (got.word_index !== want.word_index)
      note_mismatch("word_index", want.word_index, got.word_index);
    if (got.last !== want.last)
      note_mismatch($sformatf("last[%0d]", want.word_index), want.last, got.last);
  endfunction

  function automatic int pick_gap();
    int roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic ihb_req_t make_request(logic [31:0] src, logic [31:0] dst,
                                            logic [15:0] len, logic [7:0] proto,
                                            logic [15:0] ident);
    ihb_req_t r;
    r.src_addr       = src;
    r.dst_addr       = dst;
    r.total_length   = len;
    r.protocol       = proto;
    r.identification = ident;
    return r;
  endfunction

  function automatic logic [31:0] pick_address();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return {8'd192, 8'd168, 16'($urandom)};
      3: return {8'd10, 24'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic ihb_req_t random_request();
    ihb_req_t r;
    r.src_addr = pick_address();
    r.dst_addr = pick_address();
    case ($urandom_range(0, 7))
      0: r.total_length = 16'($urandom_range(0, 19));
      1, 2: r.total_length = 16'($urandom_range(20, 1500));
      3: r.total_length = 16'hFFFF;
      default: r.total_length = 16'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0: r.protocol = PROTO_TCP;
      1: r.protocol = PROTO_UDP;
      2: r.protocol = PROTO_ICMP;
      default: r.protocol = 8'($urandom);
    endcase
    r.identification = 16'($urandom);
    return r;
  endfunction

  function automatic void queue_request(ihb_req_t r);
    request_backlog.push_back(r);
    requests_sent++;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_TTL: ttl_setting = value[7:0];
      REG_DF:  df_setting = value[0];
      default: ;
    endcase
  endtask

  // Hold until every request is taken and every header word has come back.
  task automatic wait_idle();
    while (requests_taken != requests_sent || header_words_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Request side: predict on each accepted beat, then load the next one after a random gap, which may be zero.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      gap_left = 0;
    end else begin
      if (push && !full) begin
        build_header(req);
        requests_taken++;
      end
      if (!push || !full) begin
        if (gap_left > 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (request_backlog.size() != 0) begin
          req <= request_backlog.pop_front();
          push <= 1'b1;
          gap_left = pick_gap();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Result side: check each accepted beat, stall at random afterwards.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      stall_left = 0;
    end else begin
      if (pop && !empty) begin
        check_word(res);
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings: TTL 255, don't-fragment set
    quiet = 1'b1;
    queue_request(make_request(32'h0000_0000, 32'h0000_0000, 16'h0000, 8'h00, 16'h0000));
    queue_request(make_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 16'hFFFF));
    queue_request(make_request(32'h0A00_0001, 32'h0A00_0002, 16'd0, PROTO_TCP, 16'h0001));
    queue_request(make_request(32'hC0A8_0101, 32'h0808_0808, 16'd19, PROTO_UDP, 16'h8000));
    queue_request(make_request(32'h7F00_0001, 32'h7F00_0001, 16'd20, PROTO_ICMP, 16'h00FF));
    queue_request(make_request(32'h8000_0000, 32'h0000_0001, 16'd1500, PROTO_TCP, 16'h7FFF));
    queue_request(make_request(32'hAAAA_AAAA, 32'h5555_5555, 16'h5555, 8'hAA, 16'hAAAA));
    queue_request(make_request(32'h5555_5555, 32'hAAAA_AAAA, 16'hAAAA, 8'h55, 16'h5555));
    queue_request(make_request(32'hC0A8_0001, 32'hC0A8_00C7, 16'd60, PROTO_TCP, 16'h1C46));
    wait_idle();

    // TTL zero, flag cleared through a value with upper bits set
    write_reg(REG_TTL, 8'h00);
    write_reg(REG_DF, 8'hFE);
    quiet = 1'b0;
    queue_request(make_request(32'h0000_0000, 32'h0000_0000, 16'h0000, 8'h00, 16'h0000));
    queue_request(make_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 16'hFFFF));
    queue_request(make_request(32'hC0A8_0A0A, 32'hE000_00FB, 16'd19, PROTO_UDP, 16'h1234));
    queue_request(make_request(32'h0102_0304, 32'hFEFD_FCFB, 16'd576, PROTO_ICMP, 16'hBEEF));
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          write_reg(REG_TTL, 8'hFF);
          write_reg(REG_DF, 8'h03);
        end
        1: begin
          write_reg(REG_TTL, 8'h01);
          write_reg(REG_DF, 8'h00);
        end
        2: begin
          write_reg(REG_TTL, 8'd64);
          write_reg(REG_DF, 8'h01);
        end
        default: begin
          write_reg(REG_TTL, 8'($urandom));
          write_reg(REG_DF, 8'($urandom));
        end
      endcase
      quiet = (p == 2);
      repeat (PHASE_REQUESTS) queue_request(random_request());
      wait_idle();
    end

    if (mismatch_count == 0 && header_words_due.size() == 0)
      $display("ipv4_header_builder: match");
    else
      $display("ipv4_header_builder: mismatch");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("ipv4_header_builder: mismatch");
    $finish;
  end

endmodule
